// File: sv/delimited_frame_receiver_ack_tracker_core_macros.svh
// Assertion macros for the frame receiver RTL.
`ifndef DELIMITED_FRAME_RECEIVER_ACK_TRACKER_CORE_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_ACK_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define DFRAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFRAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dfrat_pkg.sv
// Shared types, codes and constants of the frame receiver.
`default_nettype none
package dfrat_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;

    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 6;
    localparam int TMO_W      = 16;
    localparam int TICK_W     = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    localparam logic [BYTE_W-1:0] ACK_CODE_RST = 8'd6;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd3000;

    localparam logic [BYTE_W-1:0] MARK_OPEN  = 8'h3C;
    localparam logic [BYTE_W-1:0] MARK_CLOSE = 8'h3E;
    localparam logic [TICK_W-1:0] TICK_MAX   = 17'h1FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] src;
        logic [LEN_W-1:0]  len;
    } t_job;

endpackage
`default_nettype wire

// File: sv/dfrat_front.sv
// Front end: frame assembly, ack wait timer and job issue.
`default_nettype none
module dfrat_front #(
    parameter int BUFFER_DEPTH = dfrat_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [dfrat_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [dfrat_pkg::BYTE_W-1:0]        i_rx_byte,
    input  wire logic                                i_cfg_we,
    input  wire logic [dfrat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dfrat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output dfrat_pkg::t_job                          o_job,
    output logic                                     o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]          o_wr_addr,
    output logic [dfrat_pkg::BYTE_W-1:0]             o_wr_data,
    input  wire logic                                i_done
);
    import dfrat_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_src, n_src;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_b2, n_b2;
    logic              r_pending, n_pending;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic              r_busy, n_busy;
    logic [BYTE_W-1:0] r_ack_code;
    logic [TMO_W-1:0]  r_timeout;

    logic              accept;
    logic              frame_ok;
    logic [TICK_W-1:0] ticks_inc;

    assign o_stall   = i_full || (r_busy && (i_func == FUNC_BYTE));
    assign accept    = i_valid && !o_stall;
    assign frame_ok  = (r_count >= CW'(2)) && ((10'(r_len) + 10'd2) == 10'(r_count));
    assign ticks_inc = (r_ticks < TICK_MAX) ? r_ticks + TICK_W'(1) : r_ticks;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = i_rx_byte;

    always_comb begin
        n_count   = r_count;
        n_src     = r_src;
        n_len     = r_len;
        n_b2      = r_b2;
        n_pending = r_pending;
        n_ticks   = r_ticks;
        n_busy    = r_busy;
        o_push    = 1'b0;
        o_job     = '0;
        o_wr_en   = 1'b0;
        if (i_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            case (i_func)
                FUNC_BYTE: begin
                    if (i_rx_byte == MARK_OPEN) begin
                        n_count = '0;
                    end else if (i_rx_byte == MARK_CLOSE) begin
                        n_count = '0;
                        if (frame_ok) begin
                            if ((r_len == 8'd1) && (r_b2 == r_ack_code)) begin
                                if (r_pending) begin
                                    n_pending  = 1'b0;
                                    n_ticks    = '0;
                                    o_push     = 1'b1;
                                    o_job.kind = KIND_ACK;
                                    o_job.src  = r_src;
                                end
                            end else begin
                                o_push     = 1'b1;
                                o_job.kind = KIND_DATA;
                                o_job.src  = r_src;
                                o_job.len  = r_len[LEN_W-1:0];
                                if (r_len != '0) begin
                                    n_busy = 1'b1;
                                end
                            end
                        end
                    end else if (r_count < CW'(BUFFER_DEPTH)) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + CW'(1);
                        if (r_count == CW'(0)) begin
                            n_src = i_rx_byte;
                        end
                        if (r_count == CW'(1)) begin
                            n_len = i_rx_byte;
                        end
                        if (r_count == CW'(2)) begin
                            n_b2 = i_rx_byte;
                        end
                    end else begin
                        n_count = '0;
                    end
                end
                FUNC_TICK: begin
                    if (r_pending) begin
                        if (ticks_inc > TICK_W'(r_timeout)) begin
                            n_pending  = 1'b0;
                            n_ticks    = '0;
                            o_push     = 1'b1;
                            o_job.kind = KIND_TIMEOUT;
                        end else begin
                            n_ticks = ticks_inc;
                        end
                    end
                end
                FUNC_SEND: begin
                    n_pending = 1'b1;
                    n_ticks   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pending  <= 1'b0;
            r_ticks    <= '0;
            r_busy     <= 1'b0;
            r_ack_code <= ACK_CODE_RST;
            r_timeout  <= TIMEOUT_RST;
        end else begin
            r_count   <= n_count;
            r_pending <= n_pending;
            r_ticks   <= n_ticks;
            r_busy    <= n_busy;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACK_CODE: r_ack_code <= i_cfg_data[BYTE_W-1:0];
                    REG_TIMEOUT:  r_timeout  <= i_cfg_data[TMO_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_src <= n_src;
        r_len <= n_len;
        r_b2  <= n_b2;
    end

endmodule
`default_nettype wire

// File: sv/dfrat_queue.sv
// Short job queue between front end and back end.
`default_nettype none
module dfrat_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dfrat_pkg::t_job i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output dfrat_pkg::t_job      o_job,
    output logic                 o_empty
);
    import dfrat_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_job            r_slot [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr;
    logic [QW-1:0]   r_rd_ptr;
    logic [QW:0]     r_used;

    assign o_full  = (r_used == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_used == '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QW'(1);
            end
            if (i_push && !i_pop) begin
                r_used <= r_used + (QW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_used <= r_used - (QW+1)'(1);
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: sv/dfrat_back.sv
// Back end: frame store and result sequencing into the output register.
`default_nettype none
`include "delimited_frame_receiver_ack_tracker_core_macros.svh"
module dfrat_back #(
    parameter int BUFFER_DEPTH = dfrat_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0]   i_wr_addr,
    input  wire logic [dfrat_pkg::BYTE_W-1:0]      i_wr_data,
    input  wire dfrat_pkg::t_job                   i_job,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    output logic                                   o_done,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [dfrat_pkg::KIND_W-1:0]           o_event_kind,
    output logic [dfrat_pkg::BYTE_W-1:0]           o_source_id,
    output logic [dfrat_pkg::LEN_W-1:0]            o_payload_len,
    output logic [dfrat_pkg::BYTE_W-1:0]           o_data_byte,
    output logic                                   o_byte_valid,
    output logic                                   o_last
);
    import dfrat_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state;

    logic [BYTE_W-1:0] r_store [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     rd_addr;

    t_state            r_state;
    t_job              r_job;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_done;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [BYTE_W-1:0] r_out_src;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic              r_out_last;

    logic              out_free;
    logic              last_idx;

    assign out_free = !r_out_valid || !i_stall;
    assign last_idx = ((LEN_W'(r_idx) + LEN_W'(1)) == r_job.len);
    assign rd_addr  = n_idx + AW'(2);

    always_comb begin
        o_pop = 1'b0;
        n_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end
            end
            S_DATA: begin
                if (out_free && !last_idx) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_idx  <= n_idx;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_job <= i_job;
                        if ((i_job.kind == KIND_DATA) && (i_job.len != '0)) begin
                            r_state <= S_DATA;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_kind   <= i_job.kind;
                            r_out_src    <= i_job.src;
                            r_out_len    <= '0;
                            r_out_byte   <= '0;
                            r_out_bvalid <= 1'b0;
                            r_out_last   <= 1'b1;
                        end
                    end
                end
                S_DATA: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_DATA;
                        r_out_src    <= r_job.src;
                        r_out_len    <= r_job.len;
                        r_out_byte   <= r_rd_data;
                        r_out_bvalid <= 1'b1;
                        r_out_last   <= last_idx;
                        if (last_idx) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_source_id   = r_out_src;
    assign o_payload_len = r_out_len;
    assign o_data_byte   = r_out_byte;
    assign o_byte_valid  = r_out_bvalid;
    assign o_last        = r_out_last;

    `DFRAT_ASSERT_IMP(a_ctl_single, i_clk, i_rst_n, r_out_valid && (r_out_kind != KIND_DATA), r_out_last && !r_out_bvalid, "ack/timeout result not single")
    `DFRAT_ASSERT_IMP(a_data_job, i_clk, i_rst_n, r_state == S_DATA, (r_job.kind == KIND_DATA) && (r_job.len != '0), "payload drain without data job")
    `DFRAT_ASSERT_NXT(a_done_last, i_clk, i_rst_n, (r_state == S_DATA) && out_free && last_idx, r_done && r_out_valid && r_out_last, "frame end not flagged")

endmodule
`default_nettype wire

// File: sv/delimited_frame_receiver_ack_tracker_core.sv
// Top level of the delimited frame receiver with ack wait tracking.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_stall      | i_func, i_rx_byte
//  out      | o_out_valid / i_out_stall    | o_event_kind .. o_last (six fields)
//  cfg      | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// An input request is taken while the four-entry job queue has room.
// A closing mark of a data frame yields len results (one if len is zero), one per cycle
// from the store read port unless the output stalls; ack and timeout yield one result each.
// Byte requests stall while the previous frame's payload is still being read out.
// Reset is synchronous; the frame store has no clear, only entries already written are read.
`default_nettype none
module delimited_frame_receiver_ack_tracker_core #(
    parameter int BUFFER_DEPTH = dfrat_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [dfrat_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [dfrat_pkg::BYTE_W-1:0]      i_rx_byte,
    input  wire logic                              i_cfg_we,
    input  wire logic [dfrat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dfrat_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [dfrat_pkg::KIND_W-1:0]           o_event_kind,
    output logic [dfrat_pkg::BYTE_W-1:0]           o_source_id,
    output logic [dfrat_pkg::LEN_W-1:0]            o_payload_len,
    output logic [dfrat_pkg::BYTE_W-1:0]           o_data_byte,
    output logic                                   o_byte_valid,
    output logic                                   o_last
);
    import dfrat_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    t_job          push_job;
    t_job          head_job;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic          done;

    dfrat_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_func     (i_func),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_full     (q_full),
        .o_push     (push),
        .o_job      (push_job),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_done     (done)
    );

    dfrat_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_empty(q_empty)
    );

    dfrat_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_job        (head_job),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_done       (done),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_source_id  (o_source_id),
        .o_payload_len(o_payload_len),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
